// ===== design/fspc_pkg.sv =====
// fspc_pkg: shared types and constants for the frustum sphere/point cull block
// no dependencies; used by frustum_sphere_point_cull and by the bench (cull_check_pkg, tb_top)

package fspc_pkg;

    // slope and margin format, unsigned Q4.12
    localparam int SLOPE_W    = 16;
    localparam int SLOPE_FRAC = 12;

    // configuration port index width (indexes past the last register are ignored)
    localparam int CFG_IDX_W  = 4;

    // number of register stages from input transaction to result register
    localparam int PIPE_DEPTH = 8;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [SLOPE_W-1:0]   slope_t;

    // configuration register indexes
    localparam cfg_idx_t REG_EYE     = 4'd0;
    localparam cfg_idx_t REG_FWD     = 4'd1;
    localparam cfg_idx_t REG_RIGHT   = 4'd2;
    localparam cfg_idx_t REG_UP      = 4'd3;
    localparam cfg_idx_t REG_NEARFAR = 4'd4;
    localparam cfg_idx_t REG_HSLOPE  = 4'd5;
    localparam cfg_idx_t REG_ASPECT  = 4'd6;
    localparam cfg_idx_t REG_MARGINS = 4'd7;

    // 1.0 in Q4.12
    localparam slope_t SLOPE_ONE = 16'h1000;

endpackage

// ===== design/fspc_if.sv =====
// fspc_if: valid/ready channel interfaces for sphere transactions and cull results
// depends on nothing; the sphere channel width follows COORD_WIDTH

interface fspc_sphere_if #(
    parameter int COORD_WIDTH = 20
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [COORD_WIDTH-2:0] radius;

    modport source (output valid, output center_x, output center_y, output center_z,
                    output radius, input ready);
    modport sink   (input valid, input center_x, input center_y, input center_z,
                    input radius, output ready);
endinterface

interface fspc_result_if ();
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink   (input valid, input inside_res, output ready);
endinterface

// ===== design/fspc_dot3.sv =====
// fspc_dot3: two-stage signed dot product of a 3-vector with a packed axis
// stage 1 registers the three products, stage 2 registers their sum; no package use

module fspc_dot3 #(
    parameter int IN_W   = 21,
    parameter int AXIS_W = 16,
    localparam int PROD_W = IN_W + AXIS_W,
    localparam int SUM_W  = PROD_W + 2
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [IN_W-1:0]   d0,
    input  logic signed [IN_W-1:0]   d1,
    input  logic signed [IN_W-1:0]   d2,
    input  logic        [3*AXIS_W-1:0] axis,
    output logic signed [SUM_W-1:0]  dot
);

    logic signed [AXIS_W-1:0] a0;
    logic signed [AXIS_W-1:0] a1;
    logic signed [AXIS_W-1:0] a2;
    logic signed [PROD_W-1:0] p0_next;
    logic signed [PROD_W-1:0] p1_next;
    logic signed [PROD_W-1:0] p2_next;
    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;

    // axis components, field 0 in the low bits
    assign a0 = $signed(axis[0*AXIS_W +: AXIS_W]);
    assign a1 = $signed(axis[1*AXIS_W +: AXIS_W]);
    assign a2 = $signed(axis[2*AXIS_W +: AXIS_W]);

    // full-width products
    always_comb
    begin
        p0_next = PROD_W'(d0) * PROD_W'(a0);
        p1_next = PROD_W'(d1) * PROD_W'(a1);
        p2_next = PROD_W'(d2) * PROD_W'(a2);
    end

    // three-term sum
    assign sum_next = SUM_W'(p0_reg) + SUM_W'(p1_reg) + SUM_W'(p2_reg);

    // payload stages, move with the pipeline enable
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            sum_reg <= sum_next;
        end
    end

    assign dot = sum_reg;

endmodule

// ===== design/frustum_sphere_point_cull.sv =====
// frustum_sphere_point_cull: radar-style frustum test of a sphere or point
// depends on fspc_pkg, fspc_if (channel interfaces) and fspc_dot3
// throughput: one transaction per cycle; the whole 8-stage pipeline holds while a result waits
// reset: valid bits clear, config registers return to zero with slope and aspect at 1.0

module frustum_sphere_point_cull #(
    parameter int COORD_WIDTH = 20,
    parameter int AXIS_WIDTH  = 16,
    localparam int EYE_W = (3 * COORD_WIDTH > 64) ? 64 : 3 * COORD_WIDTH,
    localparam int AXR_W = (3 * AXIS_WIDTH > 64) ? 64 : 3 * AXIS_WIDTH,
    localparam int NF_W  = (2 * COORD_WIDTH > 64) ? 64 : 2 * COORD_WIDTH,
    localparam int CFG_A = (EYE_W > AXR_W) ? EYE_W : AXR_W,
    localparam int CFG_B = (NF_W > 2 * fspc_pkg::SLOPE_W) ? NF_W : 2 * fspc_pkg::SLOPE_W,
    localparam int CFG_W = (CFG_A > CFG_B) ? CFG_A : CFG_B
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  fspc_pkg::cfg_idx_t   cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    fspc_sphere_if.sink          sphere,
    fspc_result_if.source        verdict
);

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = AXIS_WIDTH;
    localparam int AF  = AW - 1;
    localparam int SF  = fspc_pkg::SLOPE_FRAC;
    localparam int SLW = fspc_pkg::SLOPE_W;
    localparam int ND  = fspc_pkg::PIPE_DEPTH;
    localparam int DW  = CW + 1;                 // eye-relative coordinate
    localparam int RW  = CW - 1;                 // radius
    localparam int FW  = CW + 1;                 // near/far widened by radius
    localparam int SW  = DW + AW + 2;            // projected distance
    localparam int RMW = RW + SLW;               // radius times margin
    localparam int MYW = SW + SLW + 1;           // depth times height slope
    localparam int BYW = MYW + 1;                // vertical bound
    localparam int CYW = BYW + 1;                // vertical compare
    localparam int LOW = MYW / 2;                // low split of the aspect multiply
    localparam int HIW = MYW - LOW;
    localparam int MXW = MYW + SLW + 1;          // horizontal extent before margin
    localparam int BXW = MXW + 1;                // horizontal bound
    localparam int CXW = BXW + 1;                // horizontal compare

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [EYE_W-1:0]       eye_reg;
    logic [AXR_W-1:0]       fwd_reg;
    logic [AXR_W-1:0]       right_reg;
    logic [AXR_W-1:0]       up_reg;
    logic [NF_W-1:0]        nf_reg;
    fspc_pkg::slope_t       hs_reg;
    fspc_pkg::slope_t       asp_reg;
    logic [2*SLW-1:0]       marg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg   <= '0;
            fwd_reg   <= '0;
            right_reg <= '0;
            up_reg    <= '0;
            nf_reg    <= '0;
            hs_reg    <= fspc_pkg::SLOPE_ONE;
            asp_reg   <= fspc_pkg::SLOPE_ONE;
            marg_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fspc_pkg::REG_EYE:     eye_reg   <= cfg_data[EYE_W-1:0];
                fspc_pkg::REG_FWD:     fwd_reg   <= cfg_data[AXR_W-1:0];
                fspc_pkg::REG_RIGHT:   right_reg <= cfg_data[AXR_W-1:0];
                fspc_pkg::REG_UP:      up_reg    <= cfg_data[AXR_W-1:0];
                fspc_pkg::REG_NEARFAR: nf_reg    <= cfg_data[NF_W-1:0];
                fspc_pkg::REG_HSLOPE:  hs_reg    <= cfg_data[SLW-1:0];
                fspc_pkg::REG_ASPECT:  asp_reg   <= cfg_data[SLW-1:0];
                fspc_pkg::REG_MARGINS: marg_reg  <= cfg_data[2*SLW-1:0];
                default: ;
            endcase
        end
    end

    // packed fields past bit 63 read as zero
    logic [3*CW-1:0] eye_ext;
    logic [3*AW-1:0] fwd_ext;
    logic [3*AW-1:0] right_ext;
    logic [3*AW-1:0] up_ext;
    logic [2*CW-1:0] nf_ext;

    assign eye_ext   = (3*CW)'(eye_reg);
    assign fwd_ext   = (3*AW)'(fwd_reg);
    assign right_ext = (3*AW)'(right_reg);
    assign up_ext    = (3*AW)'(up_reg);
    assign nf_ext    = (2*CW)'(nf_reg);

    logic signed [CW-1:0] near_val;
    logic signed [CW-1:0] far_val;

    assign near_val = $signed(nf_ext[0 +: CW]);
    assign far_val  = $signed(nf_ext[CW +: CW]);

    // ---------------------------------------------------------------
    // pipeline control: one advance for every stage
    // ---------------------------------------------------------------
    logic          adv;
    logic [ND-1:0] vld_reg;

    assign adv          = !vld_reg[ND-1] || verdict.ready;
    assign sphere.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[ND-2:0], sphere.valid};
        end
    end

    // ---------------------------------------------------------------
    // stage 1: eye-relative center
    // ---------------------------------------------------------------
    logic signed [DW-1:0] dx1_next;
    logic signed [DW-1:0] dy1_next;
    logic signed [DW-1:0] dz1_next;
    logic signed [DW-1:0] dx1_reg;
    logic signed [DW-1:0] dy1_reg;
    logic signed [DW-1:0] dz1_reg;
    logic [RW-1:0]        r1_reg;

    always_comb
    begin
        dx1_next = DW'(sphere.center_x) - DW'($signed(eye_ext[0*CW +: CW]));
        dy1_next = DW'(sphere.center_y) - DW'($signed(eye_ext[1*CW +: CW]));
        dz1_next = DW'(sphere.center_z) - DW'($signed(eye_ext[2*CW +: CW]));
    end

    // ---------------------------------------------------------------
    // stages 2-3: projections onto forward, up and right axes
    // ---------------------------------------------------------------
    logic signed [SW-1:0] dz3;
    logic signed [SW-1:0] dy3;
    logic signed [SW-1:0] dx3;

    fspc_dot3 #(.IN_W(DW), .AXIS_W(AW)) u_dot_fwd (
        .clk  (clk),
        .en   (adv),
        .d0   (dx1_reg),
        .d1   (dy1_reg),
        .d2   (dz1_reg),
        .axis (fwd_ext),
        .dot  (dz3)
    );

    fspc_dot3 #(.IN_W(DW), .AXIS_W(AW)) u_dot_up (
        .clk  (clk),
        .en   (adv),
        .d0   (dx1_reg),
        .d1   (dy1_reg),
        .d2   (dz1_reg),
        .axis (up_ext),
        .dot  (dy3)
    );

    fspc_dot3 #(.IN_W(DW), .AXIS_W(AW)) u_dot_right (
        .clk  (clk),
        .en   (adv),
        .d0   (dx1_reg),
        .d1   (dy1_reg),
        .d2   (dz1_reg),
        .axis (right_ext),
        .dot  (dx3)
    );

    // radius terms alongside the projections
    logic signed [FW-1:0] farr2_next;
    logic signed [FW-1:0] nearr2_next;
    logic [RMW-1:0]       rvm2_next;
    logic [RMW-1:0]       rhm2_next;
    logic signed [FW-1:0] farr2_reg;
    logic signed [FW-1:0] nearr2_reg;
    logic [RMW-1:0]       rvm2_reg;
    logic [RMW-1:0]       rhm2_reg;
    logic signed [FW-1:0] farr3_reg;
    logic signed [FW-1:0] nearr3_reg;
    logic [RMW-1:0]       rvm3_reg;
    logic [RMW-1:0]       rhm3_reg;

    always_comb
    begin
        farr2_next  = FW'(far_val) + FW'($signed({1'b0, r1_reg}));
        nearr2_next = FW'(near_val) - FW'($signed({1'b0, r1_reg}));
        rvm2_next   = RMW'(r1_reg) * RMW'(marg_reg[SLW-1:0]);
        rhm2_next   = RMW'(r1_reg) * RMW'(marg_reg[2*SLW-1:SLW]);
    end

    // ---------------------------------------------------------------
    // stage 4: depth test and depth times height slope
    // ---------------------------------------------------------------
    logic signed [SW-1:0]  far_al;
    logic signed [SW-1:0]  near_al;
    logic                  depth_out4_next;
    logic signed [MYW-1:0] maxy4_next;
    logic                  depth_out4_reg;
    logic signed [MYW-1:0] maxy4_reg;
    logic signed [SW-1:0]  dy4_reg;
    logic signed [SW-1:0]  dx4_reg;
    logic [RMW-1:0]        rvm4_reg;
    logic [RMW-1:0]        rhm4_reg;

    always_comb
    begin
        far_al          = SW'(farr3_reg) <<< AF;
        near_al         = SW'(nearr3_reg) <<< AF;
        depth_out4_next = (far_al < dz3) || (dz3 < near_al);
        maxy4_next      = MYW'(dz3) * MYW'($signed({1'b0, hs_reg}));
    end

    // ---------------------------------------------------------------
    // stage 5: vertical bound, split aspect multiply
    // ---------------------------------------------------------------
    logic signed [BYW-1:0]     rvm_al;
    logic signed [BYW-1:0]     by5_next;
    logic [LOW+SLW-1:0]        mlo5_next;
    logic signed [HIW+SLW:0]   mhi5_next;
    logic signed [BYW-1:0]     by5_reg;
    logic [LOW+SLW-1:0]        mlo5_reg;
    logic signed [HIW+SLW:0]   mhi5_reg;
    logic                      cull5_reg;
    logic signed [SW-1:0]      dy5_reg;
    logic signed [SW-1:0]      dx5_reg;
    logic [RMW-1:0]            rhm5_reg;

    always_comb
    begin
        rvm_al    = $signed(BYW'(rvm4_reg)) <<< AF;
        by5_next  = BYW'(maxy4_reg) + rvm_al;
        mlo5_next = (LOW+SLW)'(maxy4_reg[LOW-1:0]) * (LOW+SLW)'(asp_reg);
        mhi5_next = (HIW+SLW+1)'($signed(maxy4_reg[MYW-1:LOW]))
                  * (HIW+SLW+1)'($signed({1'b0, asp_reg}));
    end

    // ---------------------------------------------------------------
    // stage 6: vertical test, horizontal extent
    // ---------------------------------------------------------------
    logic signed [CYW-1:0] dy_al;
    logic signed [CYW-1:0] by_ext;
    logic signed [CYW-1:0] by_neg;
    logic                  cull6_next;
    logic signed [MXW-1:0] maxx6_next;
    logic                  cull6_reg;
    logic signed [MXW-1:0] maxx6_reg;
    logic signed [SW-1:0]  dx6_reg;
    logic [RMW-1:0]        rhm6_reg;

    always_comb
    begin
        dy_al      = CYW'(dy5_reg) <<< SF;
        by_ext     = CYW'(by5_reg);
        by_neg     = -by_ext;
        cull6_next = cull5_reg || (by_ext < dy_al) || (dy_al < by_neg);
        maxx6_next = (MXW'(mhi5_reg) <<< LOW) + MXW'($signed({1'b0, mlo5_reg}));
    end

    // ---------------------------------------------------------------
    // stage 7: horizontal bound
    // ---------------------------------------------------------------
    logic signed [BXW-1:0] rhm_al;
    logic signed [BXW-1:0] bx7_next;
    logic signed [BXW-1:0] bx7_reg;
    logic                  cull7_reg;
    logic signed [SW-1:0]  dx7_reg;

    always_comb
    begin
        rhm_al   = $signed(BXW'(rhm6_reg)) <<< (AF + SF);
        bx7_next = BXW'(maxx6_reg) + rhm_al;
    end

    // ---------------------------------------------------------------
    // stage 8: horizontal test, result register
    // ---------------------------------------------------------------
    logic signed [CXW-1:0] dx_al;
    logic signed [CXW-1:0] bx_ext;
    logic signed [CXW-1:0] bx_neg;
    logic                  res_next;
    logic                  res_reg;

    always_comb
    begin
        dx_al    = CXW'(dx7_reg) <<< (2 * SF);
        bx_ext   = CXW'(bx7_reg);
        bx_neg   = -bx_ext;
        res_next = !(cull7_reg || (bx_ext < dx_al) || (dx_al < bx_neg));
    end

    // payload registers of all stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg        <= dx1_next;
            dy1_reg        <= dy1_next;
            dz1_reg        <= dz1_next;
            r1_reg         <= sphere.radius;

            farr2_reg      <= farr2_next;
            nearr2_reg     <= nearr2_next;
            rvm2_reg       <= rvm2_next;
            rhm2_reg       <= rhm2_next;

            farr3_reg      <= farr2_reg;
            nearr3_reg     <= nearr2_reg;
            rvm3_reg       <= rvm2_reg;
            rhm3_reg       <= rhm2_reg;

            depth_out4_reg <= depth_out4_next;
            maxy4_reg      <= maxy4_next;
            dy4_reg        <= dy3;
            dx4_reg        <= dx3;
            rvm4_reg       <= rvm3_reg;
            rhm4_reg       <= rhm3_reg;

            by5_reg        <= by5_next;
            mlo5_reg       <= mlo5_next;
            mhi5_reg       <= mhi5_next;
            cull5_reg      <= depth_out4_reg;
            dy5_reg        <= dy4_reg;
            dx5_reg        <= dx4_reg;
            rhm5_reg       <= rhm4_reg;

            cull6_reg      <= cull6_next;
            maxx6_reg      <= maxx6_next;
            dx6_reg        <= dx5_reg;
            rhm6_reg       <= rhm5_reg;

            bx7_reg        <= bx7_next;
            cull7_reg      <= cull6_reg;
            dx7_reg        <= dx6_reg;

            res_reg        <= res_next;
        end
    end

    // result channel
    assign verdict.valid      = vld_reg[ND-1];
    assign verdict.inside_res = res_reg;

`ifndef SYNTH
    // an item already culled by depth or vertical test never comes out inside
    a_cull_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[ND-2] && cull7_reg |=> !verdict.inside_res)
        else $error("culled transaction reported inside");

    // a held pipeline neither drops nor duplicates transactions
    a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

    // an accepted transaction occupies the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        sphere.valid && sphere.ready |=> vld_reg[0])
        else $error("accepted transaction missing from first stage");
`endif

endmodule

// ===== bench/cull_check_pkg.sv =====
// cull_check_pkg: sphere transaction type, wide arithmetic helpers and the verdict scoreboard
// depends on fspc_pkg (register indexes, slope format); used by tb_top

package cull_check_pkg;

    import fspc_pkg::*;

    localparam int COORD_W   = 20;
    localparam int AXIS_W    = 16;
    localparam int AXIS_FRAC = AXIS_W - 1;
    localparam int CFG_W     = 3 * COORD_W;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-2:0] radius_t;
    typedef logic [AXIS_W-1:0]  axis_t;
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        coord_t  center_x;
        coord_t  center_y;
        coord_t  center_z;
        radius_t radius;
    } sphere_t;

    // sign-extend a coordinate to full width
    function automatic wide_t from_coord(coord_t v);
        return {{(128-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    // sign-extend an axis component to full width
    function automatic wide_t from_axis(axis_t v);
        return {{(128-AXIS_W){v[AXIS_W-1]}}, v};
    endfunction

    // zero-extend an unsigned quantity to full width
    function automatic wide_t from_unsigned(logic [63:0] v);
        return {64'b0, v};
    endfunction

    class cull_scoreboard;
        logic [CFG_W-1:0]     eye_reg;
        logic [3*AXIS_W-1:0]  fwd_reg;
        logic [3*AXIS_W-1:0]  right_reg;
        logic [3*AXIS_W-1:0]  up_reg;
        logic [2*COORD_W-1:0] nearfar_reg;
        slope_t               hslope_reg;
        slope_t               aspect_reg;
        logic [2*SLOPE_W-1:0] margin_reg;
        bit                   inside_q[$];
        int                   mismatches;

        function new();
            eye_reg     = '0;
            fwd_reg     = '0;
            right_reg   = '0;
            up_reg      = '0;
            nearfar_reg = '0;
            hslope_reg  = SLOPE_ONE;
            aspect_reg  = SLOPE_ONE;
            margin_reg  = '0;
            mismatches  = 0;
        endfunction

        // register write as seen by the block; unknown indexes do nothing
        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_EYE:     eye_reg     = val;
                REG_FWD:     fwd_reg     = val[3*AXIS_W-1:0];
                REG_RIGHT:   right_reg   = val[3*AXIS_W-1:0];
                REG_UP:      up_reg      = val[3*AXIS_W-1:0];
                REG_NEARFAR: nearfar_reg = val[2*COORD_W-1:0];
                REG_HSLOPE:  hslope_reg  = val[SLOPE_W-1:0];
                REG_ASPECT:  aspect_reg  = val[SLOPE_W-1:0];
                REG_MARGINS: margin_reg  = val[2*SLOPE_W-1:0];
                default: ;
            endcase
        endfunction

        // radar test of one sphere against the current frustum, exact at 128 bits
        function bit predict_inside(sphere_t s);
            coord_t ctr[3];
            wide_t  rel;
            wide_t  depth, vert, horiz, rad, near_b, far_b;
            wide_t  max_v, bound_v, max_h, bound_h, vert_al, horiz_al;
            ctr[0] = s.center_x;
            ctr[1] = s.center_y;
            ctr[2] = s.center_z;
            depth  = '0;
            vert   = '0;
            horiz  = '0;
            // project eye-relative center onto the three axes
            for (int i = 0; i < 3; i++)
            begin
                rel   = from_coord(ctr[i]) - from_coord(eye_reg[COORD_W*i +: COORD_W]);
                depth = depth + rel * from_axis(fwd_reg[AXIS_W*i +: AXIS_W]);
                vert  = vert  + rel * from_axis(up_reg[AXIS_W*i +: AXIS_W]);
                horiz = horiz + rel * from_axis(right_reg[AXIS_W*i +: AXIS_W]);
            end
            rad    = from_unsigned(64'(s.radius));
            near_b = from_coord(nearfar_reg[COORD_W-1:0]);
            far_b  = from_coord(nearfar_reg[2*COORD_W-1:COORD_W]);

            // depth window widened by the radius
            if (((far_b + rad) <<< AXIS_FRAC) < depth || depth < ((near_b - rad) <<< AXIS_FRAC))
                return 1'b0;

            // vertical bound: depth times slope plus radius times vertical margin
            max_v   = depth * from_unsigned(64'(hslope_reg));
            bound_v = max_v + ((rad * from_unsigned(64'(margin_reg[SLOPE_W-1:0]))) <<< AXIS_FRAC);
            vert_al = vert <<< SLOPE_FRAC;
            if (vert_al > bound_v || vert_al < -bound_v)
                return 1'b0;

            // horizontal bound scaled by aspect, radius times horizontal margin
            max_h    = max_v * from_unsigned(64'(aspect_reg));
            bound_h  = max_h + ((rad * from_unsigned(64'(margin_reg[2*SLOPE_W-1:SLOPE_W])))
                                <<< (AXIS_FRAC + SLOPE_FRAC));
            horiz_al = horiz <<< (2 * SLOPE_FRAC);
            if (horiz_al > bound_h || horiz_al < -bound_h)
                return 1'b0;

            return 1'b1;
        endfunction

        // accepted sphere transaction: queue its verdict
        function void note_sphere(sphere_t s);
            inside_q.push_back(predict_inside(s));
        endfunction

        // accepted result transaction: compare with oldest verdict
        function void check_verdict(logic got);
            bit want;
            if (inside_q.size() == 0)
            begin
                $error("inside_res: unexpected transaction, expected none, actual %0b", got);
                mismatches++;
            end
            else
            begin
                want = inside_q.pop_front();
                if (got !== want)
                begin
                    $error("inside_res: expected %0b, actual %0b", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return inside_q.size();
        endfunction
    endclass

endpackage

// ===== bench/tb_top.sv =====
// tb_top: drives sphere transactions through frustum_sphere_point_cull under several frustums
// depends on fspc_pkg, fspc_if and cull_check_pkg (scoreboard)

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import fspc_pkg::*;
    import cull_check_pkg::*;

    localparam int ONE_Q8          = 256;
    localparam int COORD_MAX       = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN       = -(1 << (COORD_W - 1));
    localparam int RADIUS_MAX      = (1 << (COORD_W - 1)) - 1;
    localparam int AXIS_UNIT       = 32767;
    localparam int AXIS_HALF_ROOT2 = 23170;
    localparam int WIDE_SPAN       = 1 << 18;
    localparam int LONG_HOLD       = 80;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 193;
    localparam int CYCLE_LIMIT     = 400000;

    localparam cfg_idx_t REG_UNUSED_LO = 4'd8;
    localparam cfg_idx_t REG_UNUSED_HI = 4'd15;

    typedef enum {SET_STANDARD, SET_NOMINAL, SET_ALL_ONES, SET_ALL_ZERO, SET_SCRAMBLED} setting_t;
    typedef enum {FRAME_BASIS, FRAME_DIAGONAL, FRAME_RANDOM} frame_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    fspc_sphere_if #(.COORD_WIDTH(COORD_W)) sph_if ();
    fspc_result_if                          res_if ();

    cull_scoreboard sb = new();

    // stimulus context shared by the driving processes
    int eye_c[3];
    int span;
    bit idle_on;
    bit hold_req;
    int unsigned cycle_count;

    frustum_sphere_point_cull #(
        .COORD_WIDTH(COORD_W),
        .AXIS_WIDTH (AXIS_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .sphere   (sph_if),
        .verdict  (res_if)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one register write, taken at the next rising edge
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // offer one sphere transaction, with an optional gap before it
    task automatic send_sphere(input sphere_t s);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            sph_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        sph_if.valid    <= 1'b1;
        sph_if.center_x <= s.center_x;
        sph_if.center_y <= s.center_y;
        sph_if.center_z <= s.center_z;
        sph_if.radius   <= s.radius;
        @(posedge clk);
        while (sph_if.ready !== 1'b1)
            @(posedge clk);
        sb.note_sphere(s);
    endtask

    // stop offering and let every verdict come back before touching registers
    task automatic wait_drained();
        sph_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    function automatic sphere_t sphere_at(int cx, int cy, int cz, int rad);
        sphere_t s;
        s.center_x = coord_t'(cx);
        s.center_y = coord_t'(cy);
        s.center_z = coord_t'(cz);
        s.radius   = radius_t'(rad);
        return s;
    endfunction

    // mostly spheres around the eye, some corner values and raw bits
    function automatic sphere_t random_sphere();
        sphere_t s;
        int      pick;
        int      corner[4];
        corner = '{COORD_MIN, COORD_MAX, 0, -1};
        pick   = $urandom_range(0, 9);
        if (pick == 0)
        begin
            s.center_x = coord_t'(corner[$urandom_range(0, 3)]);
            s.center_y = coord_t'(corner[$urandom_range(0, 3)]);
            s.center_z = coord_t'(corner[$urandom_range(0, 3)]);
        end
        else if (pick < 3)
        begin
            s.center_x = coord_t'($urandom);
            s.center_y = coord_t'($urandom);
            s.center_z = coord_t'($urandom);
        end
        else
        begin
            s.center_x = coord_t'(eye_c[0] + int'($urandom_range(0, 2 * span)) - span);
            s.center_y = coord_t'(eye_c[1] + int'($urandom_range(0, 2 * span)) - span);
            s.center_z = coord_t'(eye_c[2] + int'($urandom_range(0, 2 * span)) - span);
        end
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: s.radius = '0;
            5:             s.radius = radius_t'(RADIUS_MAX);
            6, 7:          s.radius = radius_t'($urandom);
            default:       s.radius = radius_t'($urandom_range(0, span / 8));
        endcase
        return s;
    endfunction

    // build and write one complete frustum setting
    task automatic apply_setting(input setting_t kind);
        int               fw[3];
        int               rt[3];
        int               uv[3];
        int               rot, fs, rs, us, near_q, far_q;
        frame_t           mode;
        logic [CFG_W-1:0] eye_w, fwd_w, rgt_w, up_w, nf_w, hs_w, asp_w, marg_w;
        eye_w  = '0;
        fwd_w  = '0;
        rgt_w  = '0;
        up_w   = '0;
        nf_w   = '0;
        hs_w   = '0;
        asp_w  = '0;
        marg_w = '0;
        case (kind)
            SET_STANDARD, SET_NOMINAL:
            begin
                mode = (kind == SET_STANDARD) ? FRAME_BASIS : frame_t'($urandom_range(0, 2));
                fw = '{0, 0, AXIS_UNIT};
                rt = '{AXIS_UNIT, 0, 0};
                uv = '{0, AXIS_UNIT, 0};
                if (mode == FRAME_DIAGONAL)
                begin
                    fw = '{AXIS_HALF_ROOT2, 0, AXIS_HALF_ROOT2};
                    rt = '{AXIS_HALF_ROOT2, 0, -AXIS_HALF_ROOT2};
                end
                if (mode == FRAME_RANDOM)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        fw[i] = int'($urandom_range(0, 16'hFFFF)) - 32768;
                        rt[i] = int'($urandom_range(0, 16'hFFFF)) - 32768;
                        uv[i] = int'($urandom_range(0, 16'hFFFF)) - 32768;
                    end
                end
                // rotate components and flip axis signs for the nominal frames
                rot = 0;
                fs  = 1;
                rs  = 1;
                us  = 1;
                if (kind == SET_NOMINAL)
                begin
                    rot = $urandom_range(0, 2);
                    fs  = $urandom_range(0, 1) ? -1 : 1;
                    rs  = $urandom_range(0, 1) ? -1 : 1;
                    us  = $urandom_range(0, 1) ? -1 : 1;
                end
                for (int i = 0; i < 3; i++)
                begin
                    fwd_w[AXIS_W*((i+rot)%3) +: AXIS_W] = axis_t'(fs * fw[i]);
                    rgt_w[AXIS_W*((i+rot)%3) +: AXIS_W] = axis_t'(rs * rt[i]);
                    up_w[AXIS_W*((i+rot)%3) +: AXIS_W]  = axis_t'(us * uv[i]);
                    eye_c[i] = (kind == SET_STANDARD) ? 0
                             : int'($urandom_range(0, 1 << 17)) - (1 << 16);
                    eye_w[COORD_W*i +: COORD_W] = coord_t'(eye_c[i]);
                end
                if (kind == SET_STANDARD)
                begin
                    near_q = ONE_Q8;
                    far_q  = 100 * ONE_Q8;
                    hs_w   = CFG_W'(SLOPE_ONE);
                    asp_w  = CFG_W'(SLOPE_ONE);
                    marg_w = CFG_W'({SLOPE_ONE, SLOPE_ONE});
                end
                else
                begin
                    near_q = int'($urandom_range(0, 5 * ONE_Q8)) - ONE_Q8;
                    far_q  = $urandom_range(16 * ONE_Q8, 400 * ONE_Q8);
                    hs_w   = CFG_W'($urandom_range(16'h0400, 16'h3000));
                    asp_w  = CFG_W'($urandom_range(16'h0800, 16'h2000));
                    marg_w = CFG_W'({16'($urandom_range(0, 16'h2000)),
                                     16'($urandom_range(0, 16'h2000))});
                end
                nf_w = CFG_W'({coord_t'(far_q), coord_t'(near_q)});
                span = far_q;
            end
            SET_ALL_ONES:
            begin
                eye_w  = '1;
                fwd_w  = '1;
                rgt_w  = '1;
                up_w   = '1;
                nf_w   = '1;
                hs_w   = '1;
                asp_w  = '1;
                marg_w = '1;
                eye_c  = '{-1, -1, -1};
                span   = WIDE_SPAN;
            end
            SET_ALL_ZERO:
            begin
                eye_c = '{0, 0, 0};
                span  = WIDE_SPAN;
            end
            default:
            begin
                // raw bits everywhere, upper data bits included
                eye_w  = CFG_W'({$urandom, $urandom});
                fwd_w  = CFG_W'({$urandom, $urandom});
                rgt_w  = CFG_W'({$urandom, $urandom});
                up_w   = CFG_W'({$urandom, $urandom});
                nf_w   = CFG_W'({$urandom, $urandom});
                hs_w   = CFG_W'({$urandom, $urandom});
                asp_w  = CFG_W'({$urandom, $urandom});
                marg_w = CFG_W'({$urandom, $urandom});
                for (int i = 0; i < 3; i++)
                    eye_c[i] = int'($signed(eye_w[COORD_W*i +: COORD_W]));
                span = WIDE_SPAN;
            end
        endcase
        write_reg(REG_EYE, eye_w);
        write_reg(REG_FWD, fwd_w);
        write_reg(REG_RIGHT, rgt_w);
        write_reg(REG_UP, up_w);
        write_reg(REG_NEARFAR, nf_w);
        write_reg(REG_HSLOPE, hs_w);
        write_reg(REG_ASPECT, asp_w);
        write_reg(REG_MARGINS, marg_w);
        // write to an unused index must leave the frustum alone
        write_reg(cfg_idx_t'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  CFG_W'({$urandom, $urandom}));
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++)
                    @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            if (res_if.valid === 1'b1)
                sb.check_verdict(res_if.inside_res);
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** frustum_sphere_point_cull: FAILED **");
        $finish;
    end

    // main sequence
    initial
    begin
        setting_t plan[PHASES];
        plan = '{SET_NOMINAL, SET_NOMINAL, SET_ALL_ONES, SET_NOMINAL,
                 SET_ALL_ZERO, SET_SCRAMBLED, SET_NOMINAL};
        idle_on  = 1'b1;
        hold_req = 1'b0;
        eye_c    = '{0, 0, 0};
        span     = WIDE_SPAN;

        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= REG_EYE;
        cfg_data        <= '0;
        sph_if.valid    <= 1'b0;
        sph_if.center_x <= '0;
        sph_if.center_y <= '0;
        sph_if.center_z <= '0;
        sph_if.radius   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frustum: field extremes
        send_sphere(sphere_at(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX));
        send_sphere(sphere_at(COORD_MIN, COORD_MIN, COORD_MIN, 0));
        send_sphere(sphere_at(0, 0, 0, 0));
        send_sphere(sphere_at(-1, 1, -1, 1));
        wait_drained();

        // axis-aligned frustum: depth window, side planes, radius rescue
        apply_setting(SET_STANDARD);
        send_sphere(sphere_at(0, 0, 10 * ONE_Q8, 0));
        send_sphere(sphere_at(0, 0, -10 * ONE_Q8, 0));
        send_sphere(sphere_at(0, 0, 200 * ONE_Q8, 0));
        send_sphere(sphere_at(0, 0, 200 * ONE_Q8, 120 * ONE_Q8));
        send_sphere(sphere_at(0, 0, ONE_Q8 / 2, ONE_Q8));
        send_sphere(sphere_at(0, 20 * ONE_Q8, 10 * ONE_Q8, 0));
        send_sphere(sphere_at(0, 20 * ONE_Q8, 10 * ONE_Q8, 15 * ONE_Q8));
        send_sphere(sphere_at(20 * ONE_Q8, 0, 10 * ONE_Q8, 0));
        send_sphere(sphere_at(-20 * ONE_Q8, 0, 10 * ONE_Q8, 11 * ONE_Q8));
        send_sphere(sphere_at(10 * ONE_Q8, 10 * ONE_Q8, 10 * ONE_Q8, 0));
        send_sphere(sphere_at(0, -10 * ONE_Q8 - 1, 10 * ONE_Q8, 0));
        send_sphere(sphere_at(COORD_MAX, COORD_MAX, COORD_MAX, 0));
        send_sphere(sphere_at(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX));
        send_sphere(sphere_at(0, 0, COORD_MAX, RADIUS_MAX));
        send_sphere(sphere_at(COORD_MIN, COORD_MAX, COORD_MIN, 0));
        send_sphere(sphere_at(-1, -1, -1, 1));

        // random phases, one frustum each; long hold in the second, no gaps in the last
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            apply_setting(plan[ph]);
            if (ph == 1)
                hold_req = 1'b1;
            if (ph == PHASES - 1)
                idle_on = 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph != PHASES - 1)
                    idle_on = ((n / 48) % 3) != 2;
                send_sphere(random_sphere());
            end
        end

        wait_drained();
        if (sb.mismatches == 0)
            $display("** frustum_sphere_point_cull: PASSED **");
        else
            $display("** frustum_sphere_point_cull: FAILED **");
        $finish;
    end

endmodule
